FILE: rtl/plt_pkg.sv
package plt_pkg;

    localparam logic [2:0] FN_FIND    = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_DELETE  = 3'd2;
    localparam logic [2:0] FN_READ    = 3'd3;
    localparam logic [2:0] FN_REPLACE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] value;
        logic [5:0]  position;
        logic [63:0] new_value;
    } plt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [63:0] data;
        logic [6:0]  length;
    } plt_result_t;

endpackage

FILE: rtl/plt_mem.sv
module plt_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_q,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/plt_ctrl.sv
module plt_ctrl #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  plt_pkg::plt_req_t    req,
    output logic                 idle,
    output logic                 done,
    input  logic                 ack,
    output plt_pkg::plt_result_t result,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  logic [63:0]          rd_q,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [63:0]          wr_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SHIFT_DN = 3'd2;
    localparam logic [2:0] S_SHIFT_UP = 3'd3;
    localparam logic [2:0] S_PUT      = 3'd4;
    localparam logic [2:0] S_READ     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    func_reg, func_next;
    logic [63:0]   value_reg, value_next;
    logic [63:0]   newv_reg, newv_next;
    logic [5:0]    pos_reg, pos_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          iss_reg, iss_next;
    logic          vld_reg, vld_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [1:0]    stat_reg, stat_next;
    logic [5:0]    rindex_reg, rindex_next;
    logic [63:0]   rdata_reg, rdata_next;

    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] last_w;
    logic [CMPW-1:0] in_pos_w;
    logic            q_hit;
    logic            at_last;
    logic            ptr_last;

    assign cnt_w    = CMPW'(cnt_reg);
    assign last_w   = cnt_w - CMPW'(1);
    assign in_pos_w = CMPW'(req.position);
    assign q_hit    = (rd_q == value_reg);
    assign at_last  = (CMPW'(idx_reg) == last_w);
    assign ptr_last = (CMPW'(ptr_reg) == last_w);

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign result = '{status: stat_reg, index: rindex_reg, data: rdata_reg,
                      length: 7'(cnt_reg)};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        newv_next   = newv_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        iss_next    = iss_reg;
        vld_next    = 1'b0;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        stat_next   = stat_reg;
        rindex_next = rindex_reg;
        rdata_next  = rdata_reg;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next   = req.func;
                    value_next  = req.value;
                    newv_next   = req.new_value;
                    pos_next    = req.position;
                    stat_next   = plt_pkg::ST_OK;
                    rindex_next = '0;
                    rdata_next  = '0;
                    hit_next    = 1'b0;
                    iss_next    = 1'b0;
                    case (req.func) inside
                        plt_pkg::FN_FIND, plt_pkg::FN_DELETE, plt_pkg::FN_REPLACE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = plt_pkg::ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                iss_next   = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        plt_pkg::FN_INSERT:
                        begin
                            if (cnt_w == CMPW'(DEPTH))
                            begin
                                stat_next  = plt_pkg::ST_FULL;
                                state_next = S_DONE;
                            end
                            else if (in_pos_w > cnt_w)
                            begin
                                stat_next  = plt_pkg::ST_RANGE;
                                state_next = S_DONE;
                            end
                            else if (in_pos_w == cnt_w)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ptr_next   = AW'(cnt_reg - CW'(1));
                                iss_next   = 1'b1;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        plt_pkg::FN_READ:
                        begin
                            if (in_pos_w < cnt_w)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req.position);
                                vld_next   = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                stat_next  = plt_pkg::ST_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN, S_SHIFT_DN:
            begin
                // walk upward, one read issued per cycle
                if (iss_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg;
                    vld_next = 1'b1;
                    idx_next = ptr_reg;
                    ptr_next = ptr_reg + AW'(1);
                    if (ptr_last)
                    begin
                        iss_next = 1'b0;
                    end
                end
                if (vld_reg && state_reg == S_SHIFT_DN)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - AW'(1);
                    if (at_last)
                    begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
                else if (vld_reg)
                begin
                    case (func_reg)
                        plt_pkg::FN_FIND:
                        begin
                            if (q_hit)
                            begin
                                rindex_next = 6'(idx_reg);
                                state_next  = S_DONE;
                            end
                            else if (at_last)
                            begin
                                stat_next  = plt_pkg::ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                        end
                        plt_pkg::FN_DELETE:
                        begin
                            if (q_hit)
                            begin
                                rindex_next = 6'(idx_reg);
                                if (at_last)
                                begin
                                    cnt_next   = cnt_reg - CW'(1);
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    // drop the read in flight, restart after the hit
                                    vld_next   = 1'b0;
                                    ptr_next   = idx_reg + AW'(1);
                                    iss_next   = 1'b1;
                                    state_next = S_SHIFT_DN;
                                end
                            end
                            else if (at_last)
                            begin
                                stat_next  = plt_pkg::ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                        end
                        plt_pkg::FN_REPLACE:
                        begin
                            if (q_hit)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = idx_reg;
                                wr_data  = newv_reg;
                                hit_next = 1'b1;
                                if (!hit_reg)
                                begin
                                    rindex_next = 6'(idx_reg);
                                end
                            end
                            if (at_last)
                            begin
                                if (!(hit_reg || q_hit))
                                begin
                                    stat_next = plt_pkg::ST_NOT_FOUND;
                                end
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // walk downward from the top entry to position
                if (iss_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg;
                    vld_next = 1'b1;
                    idx_next = ptr_reg;
                    ptr_next = ptr_reg - AW'(1);
                    if (ptr_reg == AW'(pos_reg))
                    begin
                        iss_next = 1'b0;
                    end
                end
                if (vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg + AW'(1);
                    if (idx_reg == AW'(pos_reg))
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg);
                wr_data    = value_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_DONE;
            end

            S_READ:
            begin
                if (vld_reg)
                begin
                    rdata_next = rd_q;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            iss_reg   <= 1'b0;
            vld_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            iss_reg   <= iss_next;
            vld_reg   <= vld_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        value_reg  <= value_next;
        newv_reg   <= newv_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        stat_reg   <= stat_next;
        rindex_reg <= rindex_next;
        rdata_reg  <= rdata_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(cnt_reg) <= CMPW'(DEPTH))
        else $error("entry count above depth");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("memory write outside a request");

    a_vld_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> $past(rd_en))
        else $error("read data flagged without a read");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && stat_reg == plt_pkg::ST_FULL) |-> cnt_w == CMPW'(DEPTH))
        else $error("full reported below depth");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ack) |=> (state_reg == S_DONE && $stable(result)))
        else $error("result changed before hand-off");

endmodule

FILE: rtl/positional_list_table.sv
// Ordered list of up to DEPTH 64-bit words held in a single-port-read,
// single-port-write memory, with an entry count cleared by reset (the words
// themselves are not cleared). One request is worked at a time; in_ready is
// high whenever the sequencer is idle, even while a finished result still
// waits in the output register. Find, delete and replace step through the
// stored entries one memory read per cycle; find stops at the first match,
// and delete continues with one moved entry per cycle after the match when
// the match is not the last entry. Insert moves the entries above position
// one per cycle.
module positional_list_table #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [63:0] value,
    input  logic [5:0]  position,
    input  logic [63:0] new_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  index,
    output logic [63:0] data,
    output logic [6:0]  length
);

    localparam int AW = $clog2(DEPTH);

    plt_pkg::plt_req_t    req;
    plt_pkg::plt_result_t ctrl_res;
    plt_pkg::plt_result_t out_res_reg;
    logic                 out_vld_reg, out_vld_next;
    logic                 idle;
    logic                 done;
    logic                 load;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [63:0]          rd_q;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [63:0]          wr_data;

    assign req = '{func: func, value: value, position: position, new_value: new_value};

    assign in_ready = idle;
    // hand a finished result over when the output register is free or draining
    assign load     = done && (!out_vld_reg || out_ready);

    plt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_valid),
        .req     (req),
        .idle    (idle),
        .done    (done),
        .ack     (load),
        .result  (ctrl_res),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_q    (rd_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    plt_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_q    (rd_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= ctrl_res;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = out_res_reg.status;
    assign index     = out_res_reg.index;
    assign data      = out_res_reg.data;
    assign length    = out_res_reg.length;

endmodule
